>>> design/sbx_pkg.sv
// shared constants, types and constant tables for the sbx crossover block
`timescale 1ns / 1ps

package sbx_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RANDOM_BITS = 16;
  localparam int QI          = 30;
  localparam int ETA_FRAC    = 8;
  localparam int NORM_W      = 34;
  localparam int LOG_W       = 36;
  localparam int MUL_W       = 36;
  localparam int DVD_W       = 43;
  localparam int DVS_W       = 17;
  localparam int T_W         = 47;

  localparam logic [RANDOM_BITS-1:0] HALF = {1'b1, {(RANDOM_BITS-1){1'b0}}};
  localparam logic [40:0] OFF_LIMIT = {1'b1, 40'b0};
  localparam logic [RANDOM_BITS:0] CROSS_PROB_RESET = 17'd58982;
  localparam logic [15:0] DIST_INDEX_RESET = 16'd5120;

  localparam logic CFG_CROSS_PROB = 1'b0;
  localparam logic CFG_DIST_INDEX = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LNORM, ST_LSQ_MUL, ST_LSQ_ACC, ST_LOGEND, ST_LBE, ST_EMUL, ST_EACC,
    ST_ESHIFT, ST_ALPHA, ST_UA, ST_DIVW, ST_OFF1, ST_OFF2, ST_OFF3, ST_SIDE, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_LOGD, PH_LOGS, PH_LOGU, PH_EXPP, PH_EXPB
  } phase_t;

  typedef logic [QI-1:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // roots 2^(2^-(i+1)), each the floor square root of the one before in q.30
  function automatic root_tab_t root_table();
    root_tab_t tab;
    logic [63:0] root;
    root = 64'd2 << QI;
    for (int i = 0; i < QI; i++) begin
      root = isqrt64(root << QI);
      tab[i] = root[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = root_table();

endpackage

>>> design/sbx_mul.sv
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module sbx_mul (
  input  logic                          clk,
  input  logic [sbx_pkg::MUL_W-1:0]     a,
  input  logic [sbx_pkg::MUL_W-1:0]     b,
  output logic [2*sbx_pkg::MUL_W-1:0]   prod
);
  import sbx_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> design/sbx_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sbx_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sbx_pkg::DVD_W-1:0]   dividend,
  input  logic [sbx_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [sbx_pkg::DVD_W-1:0]   quotient
);
  import sbx_pkg::*;

  logic              busy;
  logic [5:0]        cnt;
  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W:0]    rem_sh;
  logic              qbit;

  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign qbit     = rem_sh >= {1'b0, divisor};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 6'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], qbit};
    end
  end

endmodule

>>> design/simulated_binary_crossover.sv
// top level: bounded simulated binary crossover, one variable per transaction
//
// input channel: in_valid / in_stall carry both parents, the bounds, the
// first_element mark and four random fractions. in_stall is high whenever
// the sequencer is busy; a new transaction is taken only in idle.
// output channel: out_valid / out_stall carry child_a, child_b, recombined.
// the result sits in an output register, so the next input transaction is
// taken while a finished result still waits for the receiver.
// a copied element goes from idle straight to the done state. for a
// recombined one, each log2 squares 30 times through the one shared
// multiplier, each exp2 steps through the 30 roots and each exponent
// division waits in the serial divider; a zero spread fraction skips
// those. a new element is taken only after the last has left the done state.
// when the receiver stalls, the result holds and the block waits in its
// done state before returning to idle.
// config: cfg_write with cfg_index and cfg_data, only while idle.
// reset (rst, synchronous) restores register defaults, clears the kept
// pair decision and empties the output register.
`timescale 1ns / 1ps

module simulated_binary_crossover (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic                                  cfg_index,
  input  logic [sbx_pkg::RANDOM_BITS:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sbx_pkg::VALUE_WIDTH-1:0] parent_a,
  input  logic signed [sbx_pkg::VALUE_WIDTH-1:0] parent_b,
  input  logic signed [sbx_pkg::VALUE_WIDTH-1:0] lower_bound,
  input  logic signed [sbx_pkg::VALUE_WIDTH-1:0] upper_bound,
  input  logic                                  first_element,
  input  logic [sbx_pkg::RANDOM_BITS-1:0]       rand_pair,
  input  logic [sbx_pkg::RANDOM_BITS-1:0]       rand_gate,
  input  logic [sbx_pkg::RANDOM_BITS-1:0]       rand_spread,
  input  logic [sbx_pkg::RANDOM_BITS-1:0]       rand_order,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sbx_pkg::VALUE_WIDTH-1:0] child_a,
  output logic signed [sbx_pkg::VALUE_WIDTH-1:0] child_b,
  output logic                                  recombined
);
  import sbx_pkg::*;

  state_t state, state_next;
  phase_t phase;

  logic [RANDOM_BITS:0] cross_probability;
  logic [15:0]          distribution_index;
  logic                 pair_crossing;

  // latched transaction
  logic signed [VALUE_WIDTH-1:0] pa, pb, lo, hi;
  logic [VALUE_WIDTH-1:0]        d, s1, s2;
  logic signed [VALUE_WIDTH:0]   sum;
  logic [RANDOM_BITS-1:0]        u;
  logic                          swap, rec, side, big;
  logic signed [VALUE_WIDTH-1:0] c1, c2;

  // log2 and exp2 working registers
  logic [NORM_W-1:0] norm;
  logic [5:0]        lsh;
  logic [30:0]       m;
  logic [QI-1:0]     lfrac;
  logic [4:0]        cnt;
  logic [LOG_W-1:0]  logd;
  logic signed [16:0] ek;
  logic [QI-1:0]     ef;
  logic [30:0]       r;
  logic [63:0]       x;
  logic              ovf;
  logic [40:0]       hp;

  // shared units
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_q;
  logic [DVS_W-1:0]   e;

  // transaction decode
  logic                          in_acc, pair_now, rec_now, out_free;
  logic signed [VALUE_WIDTH-1:0] y1, y2;
  logic signed [VALUE_WIDTH:0]   dd, ds1, ds2;

  // combinational arithmetic
  logic [LOG_W-1:0]  logv, neg;
  logic [LOG_W:0]    lbd;
  logic [LOG_W-1:0]  lb;
  logic [31:0]       sq;
  logic signed [T_W-1:0] t_lbe, t_div;
  logic [16:0]       negk;
  logic [63:0]       ev;
  logic [31:0]       alpha;
  logic [47:0]       pua;
  logic              big_now, ua_zero;
  logic [31:0]       ua;
  logic [33:0]       ua_arg;
  logic [VALUE_WIDTH-1:0] s_side;
  logic [41:0]       sumo;
  logic [40:0]       off;
  logic signed [42:0] v, cv, lo_x, hi_x;
  logic signed [VALUE_WIDTH-1:0] cc;
  logic              ebit;

  assign e        = DVS_W'({1'b0, distribution_index} + 17'd256);
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pair_now = first_element ? ({1'b0, rand_pair} <= cross_probability) : pair_crossing;
  assign rec_now  = pair_now && (rand_gate <= HALF) && (parent_a != parent_b);
  assign y1  = (parent_a < parent_b) ? parent_a : parent_b;
  assign y2  = (parent_a < parent_b) ? parent_b : parent_a;
  assign dd  = {y2[VALUE_WIDTH-1], y2} - {y1[VALUE_WIDTH-1], y1};
  assign ds1 = {y1[VALUE_WIDTH-1], y1} - {lower_bound[VALUE_WIDTH-1], lower_bound};
  assign ds2 = {upper_bound[VALUE_WIDTH-1], upper_bound} - {y2[VALUE_WIDTH-1], y2};

  assign logv  = {6'd33 - lsh, lfrac};
  assign neg   = LOG_W'(64'd30 << QI) - logv;
  assign lbd   = {1'b0, logv} - {1'b0, logd};
  assign lb    = lbd[LOG_W] ? '0 : lbd[LOG_W-1:0];
  assign sq    = prod[61:30];
  assign t_lbe = -$signed({2'b00, prod[52:8]});
  assign t_div = big ? $signed({12'b0, div_q[34:0]}) : -$signed({12'b0, div_q[34:0]});
  assign ebit  = ef[5'd29 - cnt];
  assign negk  = -ek;

  always_comb begin
    if (!ek[16]) begin
      ev = (ek > 17'sd32) ? {1'b1, 63'b0} : ({33'b0, r} << ek[5:0]);
    end else begin
      ev = (negk >= 17'd63) ? 64'd0 : ({33'b0, r} >> negk[5:0]);
    end
  end

  assign alpha   = 32'h8000_0000 - x[31:0];
  assign pua     = prod[47:0];
  assign big_now = pua > (48'd1 << 46);
  assign ua      = pua[47:16];
  assign ua_zero = !big_now && (ua == 32'd0);
  assign ua_arg  = big_now ? 34'(33'h0_8000_0000 - {1'b0, ua}) : {2'b00, ua};
  assign s_side  = side ? s2 : s1;

  assign sumo = {1'b0, hp} + {10'b0, prod[61:30]};
  assign off  = ovf ? OFF_LIMIT : ((sumo > {1'b0, OFF_LIMIT}) ? OFF_LIMIT : sumo[40:0]);
  assign v    = side ? ({{10{sum[VALUE_WIDTH]}}, sum} + $signed({2'b0, off}))
                     : ({{10{sum[VALUE_WIDTH]}}, sum} - $signed({2'b0, off}));
  assign lo_x = {{11{lo[VALUE_WIDTH-1]}}, lo};
  assign hi_x = {{11{hi[VALUE_WIDTH-1]}}, hi};

  // floor halving, then lower clamp, then upper clamp
  always_comb begin
    cv = v >>> 1;
    if (cv < lo_x) cv = lo_x;
    if (cv > hi_x) cv = hi_x;
    cc = cv[VALUE_WIDTH-1:0];
  end

  sbx_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sbx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({neg[34:0], 8'b0}),
    .divisor  (e),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = rec_now ? ST_LNORM : ST_DONE;
      ST_LNORM:   if (norm[NORM_W-1]) state_next = ST_LSQ_MUL;
      ST_LSQ_MUL: state_next = ST_LSQ_ACC;
      ST_LSQ_ACC: state_next = (cnt == 5'd29) ? ST_LOGEND : ST_LSQ_MUL;
      ST_LOGEND: begin
        case (phase)
          PH_LOGD: state_next = ST_SIDE;
          PH_LOGS: state_next = ST_LBE;
          default: state_next = ST_DIVW;
        endcase
      end
      ST_SIDE:    state_next = ST_LNORM;
      ST_LBE:     state_next = ST_EMUL;
      ST_EMUL: begin
        if (ebit) state_next = ST_EACC;
        else if (cnt == 5'd29) state_next = ST_ESHIFT;
      end
      ST_EACC:    state_next = (cnt == 5'd29) ? ST_ESHIFT : ST_EMUL;
      ST_ESHIFT:  state_next = (phase == PH_EXPP) ? ST_ALPHA : ST_OFF1;
      ST_ALPHA:   state_next = ST_UA;
      ST_UA:      state_next = ua_zero ? ST_OFF1 : ST_LNORM;
      ST_DIVW:    if (div_done) state_next = ST_EMUL;
      ST_OFF1:    state_next = ST_OFF2;
      ST_OFF2:    state_next = ST_OFF3;
      ST_OFF3:    state_next = side ? ST_DONE : ST_SIDE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // shared unit operands
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state)
      ST_LSQ_MUL: begin
        mul_a = {5'b0, m};
        mul_b = {5'b0, m};
      end
      ST_LOGEND: begin
        if (phase == PH_LOGS) begin
          mul_a = lb;
          mul_b = {19'b0, e};
        end
        div_start = (phase == PH_LOGU);
      end
      ST_EMUL: begin
        mul_a = {5'b0, r};
        mul_b = {5'b0, ROOTS[cnt]};
      end
      ST_ALPHA: begin
        mul_a = {20'b0, u};
        mul_b = {4'b0, alpha};
      end
      ST_OFF1: begin
        mul_a = {2'b0, x[63:30]};
        mul_b = {4'b0, d};
      end
      ST_OFF2: begin
        mul_a = {6'b0, x[29:0]};
        mul_b = {4'b0, d};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      cross_probability  <= CROSS_PROB_RESET;
      distribution_index <= DIST_INDEX_RESET;
      pair_crossing      <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == CFG_CROSS_PROB) cross_probability <= cfg_data;
        else distribution_index <= cfg_data[15:0];
      end
      if (in_acc) pair_crossing <= pair_now;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          pa   <= parent_a;
          pb   <= parent_b;
          lo   <= lower_bound;
          hi   <= upper_bound;
          u    <= rand_spread;
          swap <= rand_order <= HALF;
          rec  <= rec_now;
          d    <= dd[VALUE_WIDTH-1:0];
          s1   <= ds1[VALUE_WIDTH] ? '0 : ds1[VALUE_WIDTH-1:0];
          s2   <= ds2[VALUE_WIDTH] ? '0 : ds2[VALUE_WIDTH-1:0];
          sum  <= {y1[VALUE_WIDTH-1], y1} + {y2[VALUE_WIDTH-1], y2};
          side <= 1'b0;
          norm <= {2'b00, dd[VALUE_WIDTH-1:0]};
          lsh  <= '0;
          phase <= PH_LOGD;
        end
      end
      ST_LNORM: begin
        if (norm[NORM_W-1:NORM_W-8] == 8'd0) begin
          norm <= norm << 8;
          lsh  <= lsh + 6'd8;
        end else if (!norm[NORM_W-1]) begin
          norm <= norm << 1;
          lsh  <= lsh + 6'd1;
        end else begin
          m     <= norm[NORM_W-1:3];
          lfrac <= '0;
          cnt   <= '0;
        end
      end
      ST_LSQ_ACC: begin
        if (sq[31]) begin
          m <= sq[31:1];
          lfrac[5'd29 - cnt] <= 1'b1;
        end else begin
          m <= sq[30:0];
        end
        cnt <= cnt + 5'd1;
      end
      ST_LOGEND: begin
        if (phase == PH_LOGD) logd <= logv;
      end
      ST_SIDE: begin
        norm  <= {2'b00, d} + {1'b0, s_side, 1'b0};
        lsh   <= '0;
        phase <= PH_LOGS;
      end
      ST_LBE: begin
        ek    <= t_lbe[T_W-1:QI];
        ef    <= t_lbe[QI-1:0];
        r     <= 31'h4000_0000;
        cnt   <= '0;
        phase <= PH_EXPP;
      end
      ST_EMUL: begin
        if (!ebit && cnt != 5'd29) cnt <= cnt + 5'd1;
      end
      ST_EACC: begin
        r <= prod[60:30];
        if (cnt != 5'd29) cnt <= cnt + 5'd1;
      end
      ST_ESHIFT: begin
        x <= ev;
      end
      ST_UA: begin
        big <= big_now;
        if (ua_zero) begin
          x <= '0;
        end else begin
          norm  <= ua_arg;
          lsh   <= '0;
          phase <= PH_LOGU;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          ek    <= t_div[T_W-1:QI];
          ef    <= t_div[QI-1:0];
          r     <= 31'h4000_0000;
          cnt   <= '0;
          phase <= PH_EXPB;
        end
      end
      ST_OFF2: begin
        ovf <= prod[65:0] > {25'b0, OFF_LIMIT};
        hp  <= prod[40:0];
      end
      ST_OFF3: begin
        if (side) c2 <= cc;
        else c1 <= cc;
        side <= 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          child_a    <= rec ? (swap ? c2 : c1) : pa;
          child_b    <= rec ? (swap ? c1 : c2) : pb;
          recombined <= rec;
        end
      end
      default: begin
        x <= x;
      end
    endcase
  end

endmodule

>>> design/sbx_checker.sv
// port-level checker for the crossover block, bound to the top level
`timescale 1ns / 1ps

module sbx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] child_a,
  input logic [31:0] child_b,
  input logic        recombined
);

  // the block is busy in the cycle after it accepts a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(child_a) && $stable(child_b) && $stable(recombined))
    else $error("stalled result changed");

  // reset empties the output register and returns to idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind simulated_binary_crossover sbx_checker u_sbx_checker (.*);

>>> bench/tb_simulated_binary_crossover.sv
// self-checking testbench for the sbx crossover block: directed table, then random pairs
`timescale 1ns / 1ps

module tb_simulated_binary_crossover;
  import sbx_pkg::*;

  typedef longint unsigned u64;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] pa, pb, lo, hi;
    logic first;
    logic [RANDOM_BITS-1:0] rp, rg, rs, ro;
  } element_t;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] ca, cb;
    logic rec;
  } children_t;

  typedef struct {
    element_t el;
    bit fixed;
    children_t want;
  } row_t;

  localparam u64 ONE_Q = 64'd1 << 30;
  localparam u64 MASK_Q = ONE_Q - 64'd1;
  localparam u64 OFFSET_CAP = 64'd1 << 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_CROSS_PROB;
  logic [RANDOM_BITS:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VALUE_WIDTH-1:0] parent_a = '0, parent_b = '0;
  logic signed [VALUE_WIDTH-1:0] lower_bound = '0, upper_bound = '0;
  logic first_element = 1'b0;
  logic [RANDOM_BITS-1:0] rand_pair = '0, rand_gate = '0, rand_spread = '0, rand_order = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_WIDTH-1:0] child_a, child_b;
  logic recombined;

  simulated_binary_crossover dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [RANDOM_BITS:0] cross_prob_q = CROSS_PROB_RESET;
  logic [15:0] eta_index_q = DIST_INDEX_RESET;
  logic pair_bit_q = 1'b0;

  children_t pending_children[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  int hold_cnt = 0;

  function automatic u64 floor_sqrt(u64 x);
    u64 r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic u64 log2_q30(u64 n);
    int k;
    u64 m, frac;
    k = 0;
    frac = 0;
    if (n == 0) n = 1;
    while (k < 63 && (n >> k) > 64'd1) k++;
    m = (k >= 30) ? (n >> (k - 30)) : (n << (30 - k));
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    return (u64'(k) << 30) | frac;
  endfunction

  function automatic u64 exp2_q30(longint t);
    longint k;
    u64 f, r, root, m;
    r = ONE_Q;
    root = 64'd2 << 30;
    if (t >= 0) begin
      k = t >>> 30;
      f = u64'(t) & MASK_Q;
    end else begin
      m = u64'(-t);
      k = -longint'((m + MASK_Q) >> 30);
      f = u64'(t - k * longint'(ONE_Q));
    end
    for (int i = 1; i <= 30; i++) begin
      root = floor_sqrt(root << 30);
      if (f[30-i]) r = (r * root) >> 30;
    end
    if (k >= 0) begin
      if (k > 32) return 64'd1 << 63;
      return r << k;
    end
    if (-k >= 63) return 0;
    return r >> (-k);
  endfunction

  function automatic u64 spread_offset(u64 d, u64 s, u64 u, u64 e);
    longint lb;
    u64 p, a, prod, ua, bq, neg, bi, bf, off;
    lb = longint'(log2_q30(d + 2 * s)) - longint'(log2_q30(d));
    if (lb < 0) lb = 0;
    p = exp2_q30(-longint'((u64'(lb) * e) >> ETA_FRAC));
    a = (64'd2 << 30) - p;
    prod = u * a;
    ua = prod >> RANDOM_BITS;
    if (prod <= (64'd1 << 46)) begin
      if (ua == 0) begin
        bq = 0;
      end else begin
        neg = (64'd30 << 30) - log2_q30(ua);
        bq = exp2_q30(-longint'((neg << ETA_FRAC) / e));
      end
    end else begin
      neg = (64'd30 << 30) - log2_q30((64'd2 << 30) - ua);
      bq = exp2_q30(longint'((neg << ETA_FRAC) / e));
    end
    bi = bq >> 30;
    bf = bq & MASK_Q;
    if (bi != 0 && d > OFFSET_CAP / bi) return OFFSET_CAP;
    off = bi * d + ((bf * d) >> 30);
    return (off > OFFSET_CAP) ? OFFSET_CAP : off;
  endfunction

  function automatic longint clamp_bounds(longint c, longint lo, longint hi);
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return c;
  endfunction

  // updates the kept pair decision and returns the expected children
  function automatic children_t cross_element(element_t el);
    children_t res;
    longint pa, pb, lo, hi, y1, y2, sum, c1, c2;
    u64 d, s1, s2, e;
    pa = longint'(el.pa);
    pb = longint'(el.pb);
    lo = longint'(el.lo);
    hi = longint'(el.hi);
    res.ca = el.pa;
    res.cb = el.pb;
    res.rec = 1'b0;
    if (el.first) pair_bit_q = ({1'b0, el.rp} <= cross_prob_q);
    if (pair_bit_q && el.rg <= HALF && pa != pb) begin
      y1 = (pa < pb) ? pa : pb;
      y2 = (pa < pb) ? pb : pa;
      d = u64'(y2 - y1);
      s1 = (y1 > lo) ? u64'(y1 - lo) : 0;
      s2 = (hi > y2) ? u64'(hi - y2) : 0;
      e = u64'(eta_index_q) + (64'd1 << ETA_FRAC);
      sum = y1 + y2;
      c1 = (sum - longint'(spread_offset(d, s1, u64'(el.rs), e))) >>> 1;
      c2 = (sum + longint'(spread_offset(d, s2, u64'(el.rs), e))) >>> 1;
      c1 = clamp_bounds(c1, lo, hi);
      c2 = clamp_bounds(c2, lo, hi);
      if (el.ro <= HALF) begin
        res.ca = c2[VALUE_WIDTH-1:0];
        res.cb = c1[VALUE_WIDTH-1:0];
      end else begin
        res.ca = c1[VALUE_WIDTH-1:0];
        res.cb = c2[VALUE_WIDTH-1:0];
      end
      res.rec = 1'b1;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // result side: random stall and in-order compare
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) hold_cnt <= pick_gap();
    end
  end

  always @(posedge clk) begin
    children_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      if (pending_children.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        exp_c = pending_children.pop_front();
        if (child_a !== exp_c.ca)
          report_mismatch($sformatf("child_a %h, expected %h", child_a, exp_c.ca));
        if (child_b !== exp_c.cb)
          report_mismatch($sformatf("child_b %h, expected %h", child_b, exp_c.cb));
        if (recombined !== exp_c.rec)
          report_mismatch($sformatf("recombined %b, expected %b", recombined, exp_c.rec));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_element(element_t el, bit fixed, children_t want);
    children_t got;
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    parent_a <= el.pa;
    parent_b <= el.pb;
    lower_bound <= el.lo;
    upper_bound <= el.hi;
    first_element <= el.first;
    rand_pair <= el.rp;
    rand_gate <= el.rg;
    rand_spread <= el.rs;
    rand_order <= el.ro;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    got = cross_element(el);
    pending_children.push_back(fixed ? want : got);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_children.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [RANDOM_BITS:0] val);
    drain();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CROSS_PROB) cross_prob_q = val;
    else eta_index_q = val[15:0];
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] fix(int whole);
    return whole <<< 16;
  endfunction

  function automatic element_t random_element(bit first);
    element_t el;
    int span;
    int base;
    el.first = first;
    el.rp = RANDOM_BITS'($urandom);
    el.rg = ($urandom_range(0, 9) < 7) ? RANDOM_BITS'($urandom_range(0, HALF))
                                       : RANDOM_BITS'($urandom);
    el.rs = RANDOM_BITS'($urandom);
    el.ro = RANDOM_BITS'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        el.pa = $urandom;
        el.pb = $urandom;
        el.lo = $urandom;
        el.hi = $urandom;
      end
      2: begin
        el.lo = fix($urandom_range(0, 200) - 100);
        el.hi = el.lo - $urandom_range(0, 1 << 20);
        el.pa = el.lo + $urandom_range(0, 1 << 22) - (1 << 21);
        el.pb = el.lo + $urandom_range(0, 1 << 22) - (1 << 21);
      end
      default: begin
        base = $urandom_range(0, 2000) - 1000;
        span = $urandom_range(1, 200);
        el.lo = fix(base) + $urandom_range(0, 65535);
        el.hi = el.lo + (span <<< 16);
        el.pa = el.lo + $urandom_range(0, span << 16);
        el.pb = ($urandom_range(0, 15) == 0) ? el.pa : el.lo + $urandom_range(0, span << 16);
      end
    endcase
    return el;
  endfunction

  task automatic random_phase(int count);
    children_t none;
    int left;
    none = '{default: '0};
    left = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == count / 2) drain();
      // mostly well-formed pairs; now and then a stray element
      if (left == 0) begin
        left = $urandom_range(1, 8);
        send_element(random_element($urandom_range(0, 9) != 0), 1'b0, none);
      end else begin
        send_element(random_element($urandom_range(0, 19) == 0), 1'b0, none);
      end
      left--;
    end
    quiet = 1'b0;
  endtask

  initial begin
    row_t rows[$];
    element_t el;
    children_t none;
    none = '{default: '0};

    el = '{fix(1), fix(2), fix(0), fix(10), 1'b0, 16'h0000, 16'h0000, 16'h4000, 16'h8001};
    rows.push_back('{el, 1'b1, '{fix(1), fix(2), 1'b0}});
    el.first = 1'b1;
    el.rp = 16'hFFFF;
    rows.push_back('{el, 1'b1, '{fix(1), fix(2), 1'b0}});
    el.first = 1'b0;
    rows.push_back('{el, 1'b1, '{fix(1), fix(2), 1'b0}});
    el.first = 1'b1;
    el.rp = 16'h0000;
    el.rg = HALF;
    rows.push_back('{el, 1'b0, none});
    el.first = 1'b0;
    el.rg = HALF + 16'd1;
    rows.push_back('{el, 1'b1, '{fix(1), fix(2), 1'b0}});
    el.rg = 16'h0000;
    el.pb = fix(1);
    rows.push_back('{el, 1'b1, '{fix(1), fix(1), 1'b0}});
    el.pb = fix(2);
    el.rs = 16'h0000;
    rows.push_back('{el, 1'b0, none});
    el.rs = 16'hFFFF;
    el.ro = 16'h0000;
    rows.push_back('{el, 1'b0, none});
    el.pa = fix(-3);
    rows.push_back('{el, 1'b0, none});
    el.lo = fix(5);
    el.hi = fix(-5);
    el.pa = fix(1);
    rows.push_back('{el, 1'b0, none});
    el = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 1'b0,
           16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
    rows.push_back('{el, 1'b0, none});
    el.lo = '0;
    el.hi = '0;
    el.rs = 16'h8000;
    rows.push_back('{el, 1'b0, none});
    el = '{fix(-4), fix(3), fix(-8), fix(8), 1'b1, 16'd58982, 16'h0000, 16'h2000, 16'h8000};
    rows.push_back('{el, 1'b0, none});
    el.rp = 16'd58983;
    rows.push_back('{el, 1'b1, '{fix(-4), fix(3), 1'b0}});
    el = '{-32'sh38000, 32'sh14000, fix(-4), fix(4), 1'b1, 16'h0000, 16'h1234, 16'h8000, 16'h4000};
    rows.push_back('{el, 1'b0, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_element(rows[i].el, rows[i].fixed, rows[i].want);

    write_reg(CFG_CROSS_PROB, 17'd65536);
    write_reg(CFG_DIST_INDEX, 17'd0);
    random_phase(PHASE_ITEMS);
    write_reg(CFG_CROSS_PROB, 17'd0);
    write_reg(CFG_DIST_INDEX, 17'd65535);
    random_phase(PHASE_ITEMS);
    // above full scale still means always
    write_reg(CFG_CROSS_PROB, 17'h1FFFF);
    write_reg(CFG_DIST_INDEX, 17'd512);
    random_phase(PHASE_ITEMS);
    write_reg(CFG_CROSS_PROB, 17'd32768);
    write_reg(CFG_DIST_INDEX, 17'd5120);
    random_phase(PHASE_ITEMS);
    write_reg(CFG_CROSS_PROB, 17'd58982);
    write_reg(CFG_DIST_INDEX, 17'd1280);
    random_phase(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
